[hw/rtl/rgbrle_pkg.sv]
// rgbrle_pkg: shared constants, types and code words of the rgb555 line rle encoder
// no dependencies; used by every file of the block by scoped names

package rgbrle_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 16;
  localparam int WORD_W  = 16;
  localparam int COLOR_W = 15;
  localparam int CFG_W   = 11;
  localparam int REP_W   = 10;
  localparam int DIM_W   = 13;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(240);

  localparam logic [WORD_W-1:0] RUN_FLAG = 16'h8000;
  localparam logic [WORD_W-1:0] EOL_WORD = 16'h9001;
  localparam logic [WORD_W-1:0] EOF_WORD = 16'hA001;
  localparam logic [WORD_W-1:0] PAD_WORD = 16'hF001;
  localparam logic [REP_W-1:0]  REP_MAX  = 10'h3FF;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_LINE_WIDTH = 1'b0,
    REG_LINE_COUNT = 1'b1
  } reg_idx_t;

  // word that closes a line
  typedef enum logic [1:0] {
    TRL_NONE = 2'd0,
    TRL_EOL  = 2'd1,
    TRL_EOF  = 2'd2
  } trl_t;

  // one pixel's worth of work for the back end
  typedef struct packed {
    logic               run;
    logic [REP_W-1:0]   cnt;
    logic               col;
    logic [COLOR_W-1:0] colour;
    trl_t               trl;
  } cmd_t;

  // effective frame geometry, already clamped, minus one
  typedef struct packed {
    logic [DIM_W-1:0] w_last;
    logic [DIM_W-1:0] h_last;
  } dims_t;

endpackage

[hw/rtl/rgbrle_ifs.sv]
// rgbrle_pix_if and rgbrle_word_if: valid/ready channels of the encoder
// depends on rgbrle_pkg for payload widths

interface rgbrle_pix_if;
  logic                          valid;
  logic                          ready;
  logic [rgbrle_pkg::PIX_W-1:0]  pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface rgbrle_word_if;
  logic                          valid;
  logic                          ready;
  logic [rgbrle_pkg::WORD_W-1:0] word;
  logic                          last_of_item;
  modport source (output valid, output word, output last_of_item, input ready);
  modport sink (input valid, input word, input last_of_item, output ready);
endinterface

[hw/rtl/rgbrle_front.sv]
// rgbrle_front: accepts pixels, tracks column/row/run state, emits commands
// depends on rgbrle_pkg and rgbrle_pix_if

module rgbrle_front (
  input  logic                clk,
  input  logic                rst_n,
  rgbrle_pix_if.sink          in_ch,
  input  rgbrle_pkg::dims_t   dims,
  input  logic                q_full,
  output logic                q_push,
  output rgbrle_pkg::cmd_t    q_cmd
);

  logic [rgbrle_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [rgbrle_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [rgbrle_pkg::COLOR_W-1:0] prev_r, prev_nxt;
  logic [rgbrle_pkg::REP_W-1:0]   rep_r, rep_nxt;
  logic [rgbrle_pkg::COLOR_W-1:0] c;
  logic                           acc;
  rgbrle_pkg::cmd_t               cmd;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;
  // drop green lsb
  assign c = {in_ch.pixel[15:6], in_ch.pixel[4:0]};

  always_comb begin
    cmd      = '0;
    cmd.trl  = rgbrle_pkg::TRL_NONE;
    cmd.colour = c;
    col_nxt  = col_r;
    row_nxt  = row_r;
    prev_nxt = prev_r;
    rep_nxt  = rep_r;
    priority if (col_r == '0) begin
      cmd.col  = 1'b1;
      prev_nxt = c;
      rep_nxt  = '0;
      col_nxt  = rgbrle_pkg::COL_W'(1);
    end else if (rgbrle_pkg::DIM_W'(col_r) < dims.w_last) begin
      if (c == prev_r) begin
        if (rep_r == rgbrle_pkg::REP_MAX) begin
          cmd.run = 1'b1;
          cmd.cnt = rgbrle_pkg::REP_MAX;
          rep_nxt = rgbrle_pkg::REP_W'(1);
        end else begin
          rep_nxt = rep_r + 1'b1;
        end
      end else begin
        cmd.run  = (rep_r != '0);
        cmd.cnt  = rep_r;
        cmd.col  = 1'b1;
        rep_nxt  = '0;
        prev_nxt = c;
      end
      col_nxt = col_r + 1'b1;
    end else begin
      cmd.run  = (rep_r != '0);
      cmd.cnt  = rep_r;
      cmd.col  = 1'b1;
      rep_nxt  = '0;
      prev_nxt = c;
      col_nxt  = '0;
      if (rgbrle_pkg::DIM_W'(row_r) >= dims.h_last) begin
        cmd.trl = rgbrle_pkg::TRL_EOF;
        row_nxt = '0;
      end else begin
        cmd.trl = rgbrle_pkg::TRL_EOL;
        row_nxt = row_r + 1'b1;
      end
    end
  end

  // pixels that only extend a run send nothing
  assign q_push = acc && (cmd.run || cmd.col);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
      rep_r  <= '0;
    end else if (acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      prev_r <= prev_nxt;
      rep_r  <= rep_nxt;
    end
  end

endmodule

[hw/rtl/rgbrle_cmd_fifo.sv]
// rgbrle_cmd_fifo: short command queue between front and back end
// depends on rgbrle_pkg

module rgbrle_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rgbrle_pkg::cmd_t  push_cmd,
  input  logic              pop,
  output rgbrle_pkg::cmd_t  pop_cmd,
  output logic              full,
  output logic              empty
);

  rgbrle_pkg::cmd_t                mem_r [rgbrle_pkg::FIFO_DEPTH];
  logic [rgbrle_pkg::FIFO_AW-1:0]  wp_r, rp_r;
  logic [rgbrle_pkg::FIFO_AW:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == (rgbrle_pkg::FIFO_AW+1)'(rgbrle_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/rgbrle_back.sv]
// rgbrle_back: expands commands into coded words, tracks frame word phase, pads
// depends on rgbrle_pkg and rgbrle_word_if

module rgbrle_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  rgbrle_pkg::cmd_t  q_cmd,
  output logic              q_pop,
  rgbrle_word_if.source     out_ch
);

  logic                           busy_r;
  logic                           run_r, col_r;
  logic [rgbrle_pkg::REP_W-1:0]   cnt_r;
  logic [rgbrle_pkg::COLOR_W-1:0] colour_r;
  rgbrle_pkg::trl_t               trl_r;
  logic [1:0]                     phase_r, phase_nxt;
  logic                           out_valid_r;
  logic [rgbrle_pkg::WORD_W-1:0]  out_word_r, word;
  logic                           out_last_r, last;
  logic                           adv, fire;

  assign adv       = !out_valid_r || out_ch.ready;
  assign fire      = busy_r && adv;
  assign phase_nxt = phase_r + 2'd1;
  assign q_pop     = !q_empty && (!busy_r || (fire && last));

  // next word in order: run flush, colour, trailer, padding
  always_comb begin
    word = rgbrle_pkg::PAD_WORD;
    last = (phase_nxt == 2'd0);
    priority if (run_r) begin
      word = rgbrle_pkg::RUN_FLAG | rgbrle_pkg::WORD_W'(cnt_r);
      last = !col_r && (trl_r == rgbrle_pkg::TRL_NONE);
    end else if (col_r) begin
      word = rgbrle_pkg::WORD_W'(colour_r);
      last = (trl_r == rgbrle_pkg::TRL_NONE);
    end else if (trl_r == rgbrle_pkg::TRL_EOL) begin
      word = rgbrle_pkg::EOL_WORD;
      last = 1'b1;
    end else if (trl_r == rgbrle_pkg::TRL_EOF) begin
      word = rgbrle_pkg::EOF_WORD;
      last = (phase_nxt == 2'd0);
    end else begin
      word = rgbrle_pkg::PAD_WORD;
      last = (phase_nxt == 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      run_r       <= 1'b0;
      col_r       <= 1'b0;
      trl_r       <= rgbrle_pkg::TRL_NONE;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) out_valid_r <= fire;
      if (fire) phase_r <= phase_nxt;
      // a new command replaces the one whose last word goes out now
      if (q_pop) begin
        busy_r <= 1'b1;
        run_r  <= q_cmd.run;
        col_r  <= q_cmd.col;
        trl_r  <= q_cmd.trl;
      end else if (fire) begin
        if (run_r) begin
          run_r <= 1'b0;
        end else if (col_r) begin
          col_r <= 1'b0;
        end else if (trl_r != rgbrle_pkg::TRL_NONE) begin
          trl_r <= rgbrle_pkg::TRL_NONE;
        end
        if (last) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cnt_r    <= q_cmd.cnt;
      colour_r <= q_cmd.colour;
    end
    if (fire) begin
      out_word_r <= word;
      out_last_r <= last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.word         = out_word_r;
  assign out_ch.last_of_item = out_last_r;

endmodule

[hw/rtl/rgb555_line_rle_encoder_top.sv]
// rgb555_line_rle_encoder_top: rgb565 to rgb555 line run-length encoder
// depends on rgbrle_pkg, rgbrle_ifs, rgbrle_front, rgbrle_cmd_fifo, rgbrle_back
// path: a pixel's command is written to the queue, loaded into the back end, and its first word registered on out_ch
// throughput: one pixel per cycle into a four-entry command queue while it is not full,
//   one word per cycle out of the single output word register while out_ch is ready
// reset: synchronous rst_n clears queue, position, run and phase, loads 320 x 240

module rgb555_line_rle_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  rgbrle_pix_if.sink                    in_ch,
  rgbrle_word_if.source                 out_ch,
  input  logic                          cfg_we,
  input  rgbrle_pkg::reg_idx_t          cfg_index,
  input  logic [rgbrle_pkg::CFG_W-1:0]  cfg_data
);

  // configuration registers
  logic [rgbrle_pkg::CFG_W-1:0] width_r, height_r;
  logic [rgbrle_pkg::DIM_W-1:0] w_eff, h_eff;
  rgbrle_pkg::dims_t            dims;

  // front to back queue
  logic             q_push, q_pop, q_full, q_empty;
  rgbrle_pkg::cmd_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rgbrle_pkg::WIDTH_RST;
      height_r <= rgbrle_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbrle_pkg::REG_LINE_WIDTH: width_r  <= cfg_data;
        rgbrle_pkg::REG_LINE_COUNT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp width to 2..max and line count to 1..max
  always_comb begin
    w_eff = rgbrle_pkg::DIM_W'(width_r);
    if (w_eff < rgbrle_pkg::DIM_W'(2)) w_eff = rgbrle_pkg::DIM_W'(2);
    if (w_eff > rgbrle_pkg::DIM_W'(rgbrle_pkg::MAX_WIDTH))
      w_eff = rgbrle_pkg::DIM_W'(rgbrle_pkg::MAX_WIDTH);
    h_eff = rgbrle_pkg::DIM_W'(height_r);
    if (h_eff < rgbrle_pkg::DIM_W'(1)) h_eff = rgbrle_pkg::DIM_W'(1);
    if (h_eff > rgbrle_pkg::DIM_W'(rgbrle_pkg::MAX_HEIGHT))
      h_eff = rgbrle_pkg::DIM_W'(rgbrle_pkg::MAX_HEIGHT);
    dims.w_last = w_eff - 1'b1;
    dims.h_last = h_eff - 1'b1;
  end

  // front end: classify each pixel, at most one command per pixel
  rgbrle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .dims   (dims),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  // decouples pixel intake from word output
  rgbrle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back end: one coded word per cycle unless stalled, frame padding to a multiple of four
  rgbrle_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[hw/rtl/rgbrle_checker.sv]
// rgbrle_checker: port-level assertions on the encoder output channel
// depends on rgbrle_pkg; bound to rgb555_line_rle_encoder_top below

module rgbrle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rgbrle_pkg::WORD_W-1:0] out_word,
  input logic                          out_last
);

  // a held word stays until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))
    else $error("out payload changed while stalled");

  // end of line always closes its pixel
  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word == rgbrle_pkg::EOL_WORD |-> out_last)
    else $error("eol word not marked last");

  // reset empties the output register
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

endmodule

bind rgb555_line_rle_encoder_top rgbrle_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.word),
  .out_last  (out_ch.last_of_item)
);
